FILE: rtl/core/mie_pkg.sv
// Shared types and constants for the modular inverse unit.
`default_nettype none
package mie_pkg;
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOT_COPRIME = 2'd1;
  localparam logic [1:0] STATUS_BAD_MOD  = 2'd2;

  // datapath operation selected by the controller
  typedef enum logic [2:0] {
    OP_IDLE   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_DIV_START = 3'd2,
    OP_DIV_STEP  = 3'd3,
    OP_ROUND  = 3'd4,
    OP_FIX_START = 3'd5,
    OP_FINISH = 3'd6
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic b_zero;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

FILE: rtl/core/mie_datapath.sv
// Datapath: serial divider, serial multiply-add and Euclid registers.
`default_nettype none
module mie_datapath import mie_pkg::*; #(
  parameter int Width = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output stat_t                 stat_o,
  input  wire logic [63:0]      value_i,
  input  wire logic [62:0]      modulus_i,
  output logic [62:0]           inverse_o,
  output logic [62:0]           divisor_o,
  output logic [1:0]            status_o
);
  localparam int CntW = $clog2(Width + 1);

  // phase of the current division: 0 residue, 1 Euclid round, 2 final reduce
  typedef enum logic [1:0] {
    PH_RES = 2'd0, PH_EUC = 2'd1, PH_FIX = 2'd2
  } ph_e;

  logic [Width-1:0] m_q, m_d, a_q, a_d, b_q, b_d;
  logic [Width-1:0] pmag_q, pmag_d, cmag_q, cmag_d;
  logic             pneg_q, pneg_d, cneg_q, cneg_d, neg_q, neg_d;
  // divider: dividend shifting out of num, remainder in rem,
  // quotient times cmag accumulated in qc
  logic [Width-1:0] num_q, num_d, qc_q, qc_d, den_q, den_d;
  logic [Width:0]   rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             div_done_q, div_done_d;
  ph_e              ph_q, ph_d;
  logic [Width-1:0] mag_w;
  logic [Width:0]   rem_sh;
  logic [62:0]      inv_q, inv_d, gcd_q, gcd_d;
  logic [1:0]       st_q, st_d;

  // magnitude of the sign-extended value (most negative wraps correctly)
  always_comb begin
    logic [Width-1:0] v;
    v = value_i[Width-1:0];
    mag_w = v[Width-1] ? (~v + Width'(1)) : v;
  end

  assign rem_sh = {rem_q[Width-1:0], num_q[Width-1]};

  always_comb begin
    m_d = m_q; a_d = a_q; b_d = b_q; pmag_d = pmag_q; cmag_d = cmag_q;
    pneg_d = pneg_q; cneg_d = cneg_q; neg_d = neg_q;
    num_d = num_q; qc_d = qc_q; den_d = den_q; rem_d = rem_q;
    cnt_d = cnt_q; div_done_d = 1'b0; ph_d = ph_q;
    inv_d = inv_q; gcd_d = gcd_q; st_d = st_q;
    unique case (cmd_i.op)
      OP_LOAD: begin
        m_d = {1'b0, modulus_i[Width-2:0]};
        neg_d = value_i[Width-1];
        num_d = mag_w; den_d = {1'b0, modulus_i[Width-2:0]};
        rem_d = '0; qc_d = '0; cnt_d = CntW'(Width); ph_d = PH_RES;
      end
      OP_DIV_START: begin
        // divide a by b
        num_d = a_q; den_d = b_q; rem_d = '0; qc_d = '0;
        cnt_d = CntW'(Width); ph_d = PH_EUC;
      end
      OP_FIX_START: begin
        num_d = pmag_q; den_d = m_q; rem_d = '0; qc_d = '0;
        cnt_d = CntW'(Width); ph_d = PH_FIX;
      end
      OP_DIV_STEP: begin
        // one restoring step; fold each quotient bit, MSB first, into q*cmag
        num_d = {num_q[Width-2:0], 1'b0};
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = rem_sh - {1'b0, den_q};
          qc_d = {qc_q[Width-2:0], 1'b0} + cmag_q;
        end else begin
          rem_d = rem_sh;
          qc_d = {qc_q[Width-2:0], 1'b0};
        end
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          div_done_d = 1'b1;
          if (ph_q == PH_RES) begin
            // residue of value, then set up Euclid
            a_d = m_q;
            b_d = (neg_q && rem_d[Width-1:0] != '0) ? m_q - rem_d[Width-1:0]
                                                  : rem_d[Width-1:0];
            pmag_d = '0; pneg_d = 1'b0; cmag_d = Width'(1); cneg_d = 1'b0;
          end
        end
      end
      OP_ROUND: begin
        // advance Euclid with quotient and remainder
        a_d = b_q; b_d = rem_q[Width-1:0];
        pmag_d = cmag_q; pneg_d = cneg_q;
        cmag_d = pmag_q + qc_q; cneg_d = ~cneg_q;
      end
      OP_FINISH: begin
        if (m_q == '0) begin
          inv_d = '0; gcd_d = '0; st_d = STATUS_BAD_MOD;
        end else if (a_q == Width'(1)) begin
          inv_d = 63'((pneg_q && rem_q[Width-1:0] != '0) ? m_q - rem_q[Width-1:0]
                                                       : rem_q[Width-1:0]);
          gcd_d = 63'(a_q); st_d = STATUS_OK;
        end else begin
          inv_d = '0; gcd_d = 63'(a_q); st_d = STATUS_NOT_COPRIME;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_done_q <= 1'b0; cnt_q <= '0; ph_q <= PH_RES;
    end else begin
      div_done_q <= div_done_d; cnt_q <= cnt_d; ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d; a_q <= a_d; b_q <= b_d; pmag_q <= pmag_d; cmag_q <= cmag_d;
    pneg_q <= pneg_d; cneg_q <= cneg_d; neg_q <= neg_d;
    num_q <= num_d; qc_q <= qc_d; den_q <= den_d; rem_q <= rem_d;
    inv_q <= inv_d; gcd_q <= gcd_d; st_q <= st_d;
  end

  assign stat_o.mod_zero = (m_q == '0);
  assign stat_o.b_zero   = (b_q == '0);
  assign stat_o.div_done = div_done_q;
  assign inverse_o = inv_q;
  assign divisor_o = gcd_q;
  assign status_o  = st_q;
endmodule
`default_nettype wire

FILE: rtl/core/mie_ctrl.sv
// Controller state machine sequencing the Euclid datapath.
`default_nettype none
module mie_ctrl import mie_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  req_valid_i,
  output logic       req_ready_o,
  output logic       rsp_valid_o,
  input  wire logic  rsp_ready_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CHECK = 8'b00000010,
    S_RES   = 8'b00000100,
    S_TEST  = 8'b00001000,
    S_EUC   = 8'b00010000,
    S_ROUND = 8'b00100000,
    S_FIX   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic   out_q, out_d;

  // output register frees the engine while a result waits
  assign rsp_valid_o = out_q;
  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    out_d = out_q && !rsp_ready_i;
    cmd_o.op = OP_IDLE;
    unique case (state_q)
      S_IDLE: if (req_valid_i && req_ready_o) begin
        cmd_o.op = OP_LOAD; state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.mod_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_DIV_STEP; state_d = S_RES;
        end
      end
      S_RES: begin
        if (stat_i.div_done) state_d = S_TEST;
        else cmd_o.op = OP_DIV_STEP;
      end
      S_TEST: begin
        if (stat_i.b_zero) begin
          cmd_o.op = OP_FIX_START; state_d = S_FIX;
        end else begin
          cmd_o.op = OP_DIV_START; state_d = S_EUC;
        end
      end
      S_EUC: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_ROUND; state_d = S_ROUND;
        end else cmd_o.op = OP_DIV_STEP;
      end
      S_ROUND: state_d = S_TEST;
      S_FIX: begin
        if (stat_i.div_done) state_d = S_DONE;
        else cmd_o.op = OP_DIV_STEP;
      end
      S_DONE: begin
        // hold until the output register is free, then load the result
        if (!out_q || rsp_ready_i) begin
          cmd_o.op = OP_FINISH; out_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; out_q <= 1'b0;
    end else begin
      state_q <= state_d; out_q <= out_d;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/modular_inverse_extended_euclid_unit.sv
// Top level of the modular inverse unit.
// Computes the inverse of a signed value modulo a positive modulus and their gcd by
// the extended Euclidean algorithm. One request at a time: a restoring divider takes
// Width steps per division and accumulates quotient times coefficient as it goes.
// A request runs a residue division, Euclid rounds of at most about 1.44*Width and a
// final reduction, or goes straight to the result for a zero modulus; the result then
// waits while the previous result still holds the output register, and the next
// request is accepted once the result is loaded.
// Status 1 flags a gcd other than one, status 2 a zero modulus; the inverse then
// reads zero.
`default_nettype none
module modular_inverse_extended_euclid_unit import mie_pkg::*; #(
  parameter int Width = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] value_i,
  input  wire logic [62:0] modulus_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [62:0]      inverse_o,
  output logic [62:0]      divisor_o,
  output logic [1:0]       status_o
);
  cmd_t  cmd;
  stat_t stat;

  mie_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(in_valid_i), .req_ready_o(in_ready_o),
    .rsp_valid_o(out_valid_o), .rsp_ready_i(out_ready_i),
    .stat_i(stat), .cmd_o(cmd)
  );

  mie_datapath #(.Width(Width)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .value_i, .modulus_i, .inverse_o, .divisor_o, .status_o
  );

  // a waiting result holds steady until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(inverse_o) &&
    $stable(divisor_o) && $stable(status_o))) else $error("result changed while waiting");
  // status code stays in range on delivery
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= STATUS_BAD_MOD)) else $error("bad status");
  // an ok result has gcd one
  a_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_OK) |-> (divisor_o == 63'd1))
    else $error("ok result without unit gcd");
endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for the modular inverse unit: self-checking with a scoreboard.
`timescale 1ns / 1ps
module tb import mie_pkg::*; ();

  localparam int unsigned CycleLimit = 10_000_000;

  typedef struct {
    logic [62:0] inverse;
    logic [62:0] divisor;
    logic [1:0]  status;
  } inv_result_t;

  // Predict inverse, gcd and status for one request; hold results in order.
  class inverse_scoreboard;
    inv_result_t pending_q[$];
    int unsigned mismatches = 0;

    function inv_result_t predict_inverse(logic [63:0] value, logic [62:0] modulus);
      inv_result_t res;
      logic [63:0] m, mag, resid, a, b, q, nb, nmag, pmag, cmag, t;
      logic        neg, pneg, cneg;
      m   = {1'b0, modulus};
      neg = value[63];
      // two's complement magnitude; the most negative value maps to 2^63 exactly
      mag = neg ? (~value + 64'd1) : value;
      if (m == 0) begin
        res.inverse = '0;
        res.divisor = '0;
        res.status  = STATUS_BAD_MOD;
        return res;
      end
      resid = mag % m;
      if (neg && resid != 0) resid = m - resid;
      a = m;
      b = resid;
      pmag = 0;
      pneg = 1'b0;
      cmag = 1;
      cneg = 1'b0;
      // Euclid rounds with the coefficient kept as magnitude and sign
      while (b != 0) begin
        q    = a / b;
        nb   = a - q * b;
        nmag = pmag + q * cmag;
        a    = b;
        b    = nb;
        pmag = cmag;
        pneg = cneg;
        cmag = nmag;
        cneg = !pneg;
      end
      res.divisor = a[62:0];
      if (a == 1) begin
        t = pmag % m;
        t = (pneg && t != 0) ? (m - t) : t;
        res.inverse = t[62:0];
        res.status  = STATUS_OK;
      end else begin
        res.inverse = '0;
        res.status  = STATUS_NOT_COPRIME;
      end
      return res;
    endfunction

    function void note_request(logic [63:0] value, logic [62:0] modulus);
      pending_q = {pending_q, predict_inverse(value, modulus)};
    endfunction

    function void check_result(logic [62:0] inverse, logic [62:0] divisor, logic [1:0] status);
      inv_result_t exp_res;
      if (pending_q.size() == 0) begin
        $error("unexpected result: inverse %0d divisor %0d status %0d",
               inverse, divisor, status);
        mismatches++;
        return;
      end
      exp_res = pending_q.pop_front();
      if (inverse !== exp_res.inverse) begin
        $error("inverse: expected %0d actual %0d", exp_res.inverse, inverse);
        mismatches++;
      end
      if (divisor !== exp_res.divisor) begin
        $error("divisor: expected %0d actual %0d", exp_res.divisor, divisor);
        mismatches++;
      end
      if (status !== exp_res.status) begin
        $error("status: expected %0d actual %0d", exp_res.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] value_i = '0;
  logic [62:0] modulus_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [62:0] inverse_o;
  logic [62:0] divisor_o;
  logic [1:0]  status_o;

  inverse_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request = 0;
  int unsigned cycle_cnt = 0;

  modular_inverse_extended_euclid_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .modulus_i  (modulus_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .inverse_o  (inverse_o),
    .divisor_o  (divisor_o),
    .status_o   (status_o)
  );

  always #4 clk_i = ~clk_i;

  // Note accepted requests and check accepted results.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_request(value_i, modulus_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(inverse_o, divisor_o, status_o);
  end

  // Drive the result ready; hold it low for a long stretch on request.
  initial begin
    int unsigned hold_cnt;
    hold_cnt = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_cnt = hold_request;
        hold_request = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Abort on a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one request and hold it until accepted.
  task automatic send_request(logic [63:0] value, logic [62:0] modulus);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    modulus_i  <= modulus;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random request: random bit lengths, signs and occasional edge moduli.
  task automatic send_random();
    logic [63:0] value, mod_bits;
    int unsigned sel, vbits, mbits;
    sel   = $urandom_range(99);
    mbits = $urandom_range(1, 63);
    vbits = $urandom_range(1, 64);
    mod_bits = rand64() & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - mbits));
    if (sel < 4) mod_bits = 0;
    else if (sel < 8) mod_bits = 1;
    value = rand64() & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - vbits));
    if (sel >= 8 && sel < 12) value = 0;
    if ($urandom_range(1)) value = -value;
    send_request(value, mod_bits[62:0]);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // sender 31 percent idle, receiver 64 percent
    send_idle_pct = 31;
    recv_idle_pct = 64;

    // directed edge cases
    send_request(64'd5, 63'd0);
    send_request(64'h8000_0000_0000_0000, 63'd0);
    send_request(64'd12345, 63'd1);
    send_request(-64'd9, 63'd1);
    send_request(64'd0, 63'd7);
    send_request(64'd0, 63'd1);
    send_request(64'd3, 63'd7);
    send_request(-64'd3, 63'd7);
    send_request(64'd6, 63'd9);
    send_request(-64'd7, 63'd7);
    send_request(64'h8000_0000_0000_0000, 63'd3);
    send_request(64'h8000_0000_0000_0000, 63'd4);
    send_request(64'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
    send_request(-64'd1, 63'h7FFF_FFFF_FFFF_FFFF);
    send_request(64'h7FFF_FFFF_FFFF_FFFE, 63'h7FFF_FFFF_FFFF_FFFF);
    send_request(64'd2, 63'h4000_0000_0000_0000);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 63'h5555_5555_5555_5555);
    send_request(64'd1, 63'd2);
    send_request(64'h0000_0001_0000_0001, 63'h2AAA_AAAA_AAAA_AAAB);

    // one long receiver hold while requests keep coming
    hold_request = 20000;
    repeat (40) send_random();

    // pause until drained, then swap the idle rates
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    send_idle_pct = 64;
    recv_idle_pct = 31;
    repeat (40) send_random();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (40) send_random();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
